>>> rtl/modular_inverse_assert.svh
// Assertion macros shared by the modular inverse modules.
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modular_inverse: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modular_inverse: next-cycle check failed");

`endif

>>> rtl/modinv_pkg.sv
// Shared types and constants for the modular inverse block.
package modinv_pkg;

  // Width of each external field
  localparam int unsigned FIELD_W = 32;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_ALIGN = 6'b000100,
    ST_SUB   = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture operands, start reduction
    logic align;  // shift divisor and coefficient left by one
    logic sub;    // one restoring-division step
    logic fold;   // bring coefficient magnitude below the modulus
    logic emit;   // load the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic b_zero;      // divisor is zero: Euclid finished
    logic align_more;  // divisor can still be doubled
    logic sub_last;    // this step is the quotient's lowest bit
    logic out_free;    // output register can take a word
  } status_t;

endpackage

>>> rtl/modinv_ctrl.sv
// Sequencer for the modular inverse: steps the shared divide unit.
`include "modular_inverse_assert.svh"

module modinv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  modinv_pkg::status_t status,
  output modinv_pkg::cmd_t    cmd
);

  modinv_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modinv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands; no word is taken during reset
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      modinv_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = modinv_pkg::ST_CHECK;
        end
      end
      modinv_pkg::ST_CHECK: begin
        if (status.b_zero) begin
          state_next = modinv_pkg::ST_FOLD;
        end else begin
          state_next = modinv_pkg::ST_ALIGN;
        end
      end
      modinv_pkg::ST_ALIGN: begin
        if (status.align_more) begin
          cmd.align = 1'b1;
        end else begin
          state_next = modinv_pkg::ST_SUB;
        end
      end
      modinv_pkg::ST_SUB: begin
        cmd.sub = 1'b1;
        if (status.sub_last) begin
          state_next = modinv_pkg::ST_CHECK;
        end
      end
      modinv_pkg::ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = modinv_pkg::ST_EMIT;
      end
      modinv_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = modinv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = modinv_pkg::ST_IDLE;
      end
    endcase
  end

  // A new word always starts with the divisor check
  `MI_ASSERT_NEXT(a_load_check, clk, rst, cmd.load, state == modinv_pkg::ST_CHECK)

endmodule

>>> rtl/modinv_dp.sv
// Datapath for the modular inverse: shift-subtract divider, continuant and output register.
`include "modular_inverse_assert.svh"

module modinv_dp #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  modinv_pkg::cmd_t               cmd,
  output modinv_pkg::status_t            status,
  input  logic [modinv_pkg::FIELD_W-1:0] value,
  input  logic [modinv_pkg::FIELD_W-1:0] modulus,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [modinv_pkg::FIELD_W-1:0] inverse,
  output logic                           has_inverse
);

  // Euclid remainders, shifted divisor, modulus
  logic [WIDTH-1:0] a, b, bs, m_reg;
  // Coefficient magnitudes: previous, current, shifted current, running sum
  logic [WIDTH-1:0] prev, cur, cs, acc;
  logic             prev_neg, cur_neg;
  logic             reduce;  // first division is value mod modulus

  logic             ge;
  logic [WIDTH-1:0] a_rem, acc_sum, prev_mod, inv_w;
  logic             ok;

  // One restoring step: subtract shifted divisor, add shifted coefficient
  assign ge      = a >= bs;
  assign a_rem   = ge ? a - bs : a;
  assign acc_sum = ge ? acc + cs : acc;

  // Fold and sign
  assign prev_mod = (prev >= m_reg) ? prev - m_reg : prev;
  assign ok       = !reduce && (a == WIDTH'(1));
  always_comb begin
    if (!ok) begin
      inv_w = '0;
    end else if (prev_neg && (prev != '0)) begin
      inv_w = m_reg - prev;
    end else begin
      inv_w = prev;
    end
  end

  // Status
  assign status.b_zero     = (b == '0);
  assign status.align_more = !bs[WIDTH-1] && ({bs, 1'b0} <= {1'b0, a});
  assign status.sub_last   = (bs == b);
  assign status.out_free   = !out_valid || out_ready;

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a        <= WIDTH'(value);
      b        <= WIDTH'(modulus);
      bs       <= WIDTH'(modulus);
      m_reg    <= WIDTH'(modulus);
      cs       <= '0;
      acc      <= '0;
      prev     <= '0;
      cur      <= '0;
      prev_neg <= 1'b0;
      cur_neg  <= 1'b0;
      reduce   <= 1'b1;
    end else if (cmd.align) begin
      bs <= bs << 1;
      cs <= cs << 1;
    end else if (cmd.sub) begin
      if (status.sub_last) begin
        // Quotient done: advance Euclid and set up the next division
        b  <= a_rem;
        bs <= a_rem;
        if (reduce) begin
          a      <= m_reg;
          prev   <= '0;
          cur    <= WIDTH'(1);
          cs     <= WIDTH'(1);
          acc    <= '0;
          reduce <= 1'b0;
        end else begin
          a        <= b;
          prev     <= cur;
          cur      <= acc_sum;
          cs       <= acc_sum;
          acc      <= cur;
          prev_neg <= cur_neg;
          cur_neg  <= !cur_neg;
        end
      end else begin
        a   <= a_rem;
        acc <= acc_sum;
        bs  <= bs >> 1;
        cs  <= cs >> 1;
      end
    end else if (cmd.fold) begin
      prev <= prev_mod;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      inverse     <= modinv_pkg::FIELD_W'(inv_w);
      has_inverse <= ok;
    end
  end

  // Partial remainder stays below twice the shifted divisor
  `MI_ASSERT_IMPL(a_rem_bound, clk, rst, cmd.sub, ({1'b0, a} < {bs, 1'b0}))
  // The shifted divisor never drops below the divisor
  `MI_ASSERT_IMPL(a_shift_floor, clk, rst, cmd.sub, bs >= b)
  // Folding only starts once Euclid has run out of divisor
  `MI_ASSERT_IMPL(a_fold_done, clk, rst, cmd.fold, b == '0)
  // A result is only loaded into a free output register
  `MI_ASSERT_IMPL(a_emit_free, clk, rst, cmd.emit, !out_valid || out_ready)

endmodule

>>> rtl/modular_inverse.sv
// Top level of the modular inverse block: stream ports, sequencer and datapath.
//
// Input stream s_*: one word carries a value and a modulus. The block
// reduces the value modulo the modulus, runs the extended Euclidean
// algorithm and returns the inverse in 0..modulus-1 on the m_* stream,
// with m_tuser set when the gcd is 1 and an inverse exists (else 0, 0).
// Only the low WIDTH bits of each operand are used.
// One word is worked on at a time; s_tready is high while the sequencer
// is idle and rst is low. Each division of Euclid runs on one shift-subtract
// unit; the reduction of the value runs on it the same way, and then the
// sequencer checks the last divisor, folds and loads the output. The time a
// word takes is set by the number of Euclid steps and of quotient bits.
// The result sits in an output register, so the next word is taken while
// a result waits; a stalled m_tready holds that result and the core waits
// only when it has another result ready. Synchronous reset (rst) empties
// the output register and returns the sequencer to idle.
module modular_inverse #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [2*modinv_pkg::FIELD_W-1:0] s_tdata,  // value [31:0], modulus [63:32]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [modinv_pkg::FIELD_W-1:0]   m_tdata,  // inverse [31:0]
  output logic [0:0]                       m_tuser   // has_inverse [0]
);

  modinv_pkg::cmd_t    cmd;
  modinv_pkg::status_t status;
  logic                has_inverse;

  modinv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  modinv_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value       (s_tdata[modinv_pkg::FIELD_W-1:0]),
    .modulus     (s_tdata[2*modinv_pkg::FIELD_W-1:modinv_pkg::FIELD_W]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .inverse     (m_tdata),
    .has_inverse (has_inverse)
  );

  assign m_tuser[0] = has_inverse;

endmodule

>>> tb/tb_modular_inverse.sv
// Testbench for modular_inverse: random and directed words checked against a local predictor.
module tb_modular_inverse;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_W = modinv_pkg::FIELD_W;

  // Watchdog: cycles with no word moving on either side
  localparam int unsigned STALL_LIMIT = 5000;
  // Quiet cycles after the last result, longer than any word's latency
  localparam int unsigned TAIL_CYCLES = 500;
  localparam int unsigned RANDOM_WORDS = 520;
  localparam int unsigned STREAM_WORDS = 80;

  typedef struct packed {
    logic [FIELD_W-1:0] inverse;
    logic               has_inverse;
  } inv_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [2*FIELD_W-1:0]   s_tdata = '0;  // value [31:0], modulus [63:32]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [FIELD_W-1:0]     m_tdata;       // inverse [31:0]
  logic [0:0]             m_tuser;       // has_inverse [0]

  inv_result_t            pending_inverses[$];
  logic                   quiet = 1'b0;  // no idling on either side
  int unsigned            errors = 0;
  int unsigned            words_sent = 0;
  int unsigned            results_checked = 0;
  int unsigned            no_inverse_seen = 0;
  int unsigned            idle_cycles = 0;
  int unsigned            sink_hold = 0;

  modular_inverse #(.WIDTH(32)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Extended Euclid on 64-bit magnitudes with a separate sign bit
  function automatic inv_result_t mod_inverse(logic [FIELD_W-1:0] value,
                                              logic [FIELD_W-1:0] modulus);
    logic [63:0] m, a, b, q, r;
    logic [63:0] prev_mag, cur_mag, next_mag, mag;
    logic        prev_neg, cur_neg;
    inv_result_t res;
    m = {32'd0, modulus};
    res = '0;
    if (m != 0) begin
      a = m;
      b = {32'd0, value} % m;
      prev_mag = 0;
      prev_neg = 1'b0;
      cur_mag = 1;
      cur_neg = 1'b0;
      while (b != 0) begin
        q = a / b;
        r = a % b;
        a = b;
        b = r;
        next_mag = q * cur_mag + prev_mag;
        prev_mag = cur_mag;
        prev_neg = cur_neg;
        cur_mag = next_mag;
        cur_neg = ~cur_neg;
      end
      if (a == 1) begin
        mag = prev_mag % m;
        res.has_inverse = 1'b1;
        if (prev_neg && mag != 0)
          res.inverse = FIELD_W'(m - mag);
        else
          res.inverse = FIELD_W'(mag);
      end
    end
    return res;
  endfunction

  // Fibonacci number n (n up to 47 fits in 32 bits)
  function automatic logic [FIELD_W-1:0] fib(int unsigned n);
    logic [FIELD_W-1:0] x, y, t;
    x = 0;
    y = 1;
    for (int unsigned i = 0; i < n; i++) begin
      t = x + y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Send one word; entered and left at a falling edge, valid may stay high
  task automatic send_word(logic [FIELD_W-1:0] value, logic [FIELD_W-1:0] modulus);
    s_tvalid <= 1'b1;
    s_tdata  <= {modulus, value};
    do @(posedge clk); while (!s_tready);
    pending_inverses.push_back(mod_inverse(value, modulus));
    words_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  // Hold the source off until every expected result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_inverses.size() != 0) @(negedge clk);
  endtask

  // Random word drawn from a mix of shapes
  task automatic send_random_word();
    logic [FIELD_W-1:0] value, modulus, g;
    int unsigned n;
    case ($urandom_range(0, 6))
      0: begin
        value = $urandom;
        modulus = $urandom_range(32'hFFFF_FFFF, 2);
      end
      1: begin
        // small modulus, big value: reduction does the work
        value = $urandom;
        modulus = $urandom_range(300, 2);
      end
      2: begin
        modulus = $urandom | 32'd1;
        if (modulus < 2) modulus = 3;
        value = $urandom_range(modulus - 1, 0);
      end
      3: begin
        modulus = 32'd1 << $urandom_range(31, 1);
        value = $urandom;
      end
      4: begin
        // shared factor: no inverse unless the product for value wraps
        g = $urandom_range(1000, 2);
        modulus = g * $urandom_range(4000000, 1);
        value = g * $urandom;
        if (modulus < 2) modulus = 2;
      end
      5: begin
        // adjacent Fibonacci numbers: longest quotient chains
        n = $urandom_range(47, 4);
        modulus = fib(n);
        value = fib(n - 1);
        if ($urandom_range(0, 1) == 1) value = value + modulus * $urandom_range(1, 0);
      end
      default: begin
        modulus = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
        value = $urandom_range(32'hFFFF_FFFF, 32'hFFF0_0000);
      end
    endcase
    send_word(value, modulus);
  endtask

  // Extremes of both fields
  task automatic test_field_extremes();
    send_word(32'd3, 32'd7);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_word(32'd1, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'd2);
    send_word(32'd1, 32'd2);
    send_word(32'd0, 32'd2);
    send_word(32'd2, 32'd4294967291);
    send_word(32'hFFFF_FFFF, 32'h8000_0000);
    send_word(32'd3, 32'h8000_0000);
    send_word(32'hAAAA_AAAA, 32'h5555_5555);
    drain_results();
  endtask

  // Cases named by the spec: reduction, zero value, moduli zero and one
  task automatic test_special_cases();
    send_word(32'd10, 32'd7);
    send_word(32'd7, 32'd7);
    send_word(32'd0, 32'd7);
    send_word(32'd0, 32'd0);
    send_word(32'd12345, 32'd0);
    send_word(32'hFFFF_FFFF, 32'd0);
    send_word(32'd5, 32'd1);
    send_word(32'hFFFF_FFFF, 32'd1);
    send_word(32'd6, 32'd9);
    send_word(32'd2, 32'h8000_0000);
    send_word(fib(46), fib(47));
    send_word(fib(47), fib(46));
    drain_results();
  endtask

  // Bulk random words with idling on both sides
  task automatic test_random_mix();
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      send_random_word();
      if (i == RANDOM_WORDS / 2) drain_results();
    end
    drain_results();
  endtask

  // Back-to-back words, no idling anywhere
  task automatic test_streaming();
    quiet = 1'b1;
    for (int unsigned i = 0; i < STREAM_WORDS; i++)
      send_random_word();
    drain_results();
  endtask

  // Sink: random stall bursts
  always @(negedge clk) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold--;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(9, 1) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker: each accepted word against the oldest prediction
  always @(posedge clk) begin
    inv_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_inverses.size() == 0) begin
        $error("unexpected result word: inverse %h has_inverse %b", m_tdata, m_tuser);
        errors++;
      end else begin
        exp_res = pending_inverses.pop_front();
        if (m_tdata !== exp_res.inverse) begin
          $error("inverse: expected %h, actual %h", exp_res.inverse, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== exp_res.has_inverse) begin
          $error("has_inverse: expected %b, actual %b", exp_res.has_inverse, m_tuser[0]);
          errors++;
        end
        results_checked++;
        if (!exp_res.has_inverse) no_inverse_seen++;
      end
    end
  end

  // Watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_field_extremes();
    test_special_cases();
    test_random_mix();
    test_streaming();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_inverses.size() != 0) begin
      $error("%0d expected results never arrived", pending_inverses.size());
      errors++;
    end
    $display("covered %0d words (extremes, zero and unit moduli, shared factors,",
             words_sent);
    $display("  Fibonacci chains, random mix); %0d results checked, %0d without inverse",
             results_checked, no_inverse_seen);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/modinv_pkg.sv
rtl/modinv_ctrl.sv
rtl/modinv_dp.sv
rtl/modular_inverse.sv
tb/tb_modular_inverse.sv
